// ----- hdl/sps_pkg.sv -----
// Shared constants, widths and controller-to-datapath types of the scheduler.
package sps_pkg;

  localparam int MAX_JOBS  = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int ARR_W     = 16;
  localparam int SVC_W     = 8;
  localparam int TICK_W    = 17;
  localparam int WAIT_W    = 14;
  localparam int TURN_W    = 15;
  localparam int SUM_W     = 20;
  localparam int AVGW_W    = 22;
  localparam int AVGT_W    = 23;
  localparam int FRAC_W    = 8;
  localparam int DIVD_W    = SUM_W + FRAC_W;
  localparam int DSTEP_W   = 5;
  localparam int DIV_STEPS = DIVD_W;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic jump;
    logic dispatch;
    logic div_start;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic last_disp;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- hdl/shortest_process_next_sched_top.sv -----
// Top level of the shortest-process-next batch scheduler.
// Jobs are loaded one per beat (start high while busy is low), up to 64 jobs;
// further jobs are dropped. A beat with in_last_job set begins the schedule and busy stays high
// until the last result. Each dispatch scans every stored job through the single read port of
// the job store, with a second scan when time must first jump to the earliest pending arrival.
// The final result waits for the bit-serial division that forms the averages. Each result
// appears for exactly one cycle with out_valid high and must be taken then; the block cannot
// be stalled.
module shortest_process_next_sched_top
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ARR_W-1:0]  in_arrival_time,
  input  logic [SVC_W-1:0]  in_service_time,
  input  logic              in_last_job,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_job_index,
  output logic [TICK_W-1:0] out_start_time,
  output logic [WAIT_W-1:0] out_wait_ticks,
  output logic [TURN_W-1:0] out_turnaround_ticks,
  output logic [AVGW_W-1:0] out_avg_wait_q8,
  output logic [AVGT_W-1:0] out_avg_turnaround_q8,
  output logic              out_final_dispatch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_job (in_last_job),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .stat        (stat)
  );

  sps_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_arrival_time       (in_arrival_time),
    .in_service_time       (in_service_time),
    .out_job_index         (out_job_index),
    .out_start_time        (out_start_time),
    .out_wait_ticks        (out_wait_ticks),
    .out_turnaround_ticks  (out_turnaround_ticks),
    .out_avg_wait_q8       (out_avg_wait_q8),
    .out_avg_turnaround_q8 (out_avg_turnaround_q8),
    .out_final_dispatch    (out_final_dispatch)
  );

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat outside a schedule");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_job) |=> !busy)
    else $error("loading beat started a schedule");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_job) |=> busy)
    else $error("last job did not start the schedule");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in consecutive cycles");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_dispatch) |=> !busy)
    else $error("block still busy after the final result");

endmodule

// ----- hdl/sps_div.sv -----
// Restoring divider that forms one quotient bit per cycle for the batch averages.
module sps_div
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic              done
);

  logic [CNT_W-1:0]   rem_r;
  logic [DIVD_W-1:0]  quo_r;
  logic [DSTEP_W-1:0] step_r;
  logic               busy_r;
  logic               done_r;
  logic [CNT_W:0]     trial;
  logic               fits;
  logic [CNT_W:0]     diff;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DSTEP_W'(1);
        if (step_r == DSTEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- hdl/sps_dp.sv -----
// Datapath: job stores, selection scan, time and sum registers, result registers and the two averaging dividers.
module sps_dp
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [ARR_W-1:0]  in_arrival_time,
  input  logic [SVC_W-1:0]  in_service_time,
  output logic [IDX_W-1:0]  out_job_index,
  output logic [TICK_W-1:0] out_start_time,
  output logic [WAIT_W-1:0] out_wait_ticks,
  output logic [TURN_W-1:0] out_turnaround_ticks,
  output logic [AVGW_W-1:0] out_avg_wait_q8,
  output logic [AVGT_W-1:0] out_avg_turnaround_q8,
  output logic              out_final_dispatch
);

  logic [ARR_W-1:0]    arr_mem [MAX_JOBS];
  logic [SVC_W-1:0]    svc_mem [MAX_JOBS];

  logic [MAX_JOBS-1:0] done_r;
  logic [CNT_W-1:0]    count_r;
  logic [TICK_W-1:0]   tick_r;
  logic [SUM_W-1:0]    wsum_r;
  logic [SUM_W-1:0]    tsum_r;
  logic [IDX_W-1:0]    disp_cnt_r;

  logic [CNT_W-1:0]    scan_addr_r;
  logic                issuing_r;
  logic                cmp_vld_r;
  logic                cmp_last_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic [ARR_W-1:0]    rd_arr_r;
  logic [SVC_W-1:0]    rd_svc_r;

  logic                best_found_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [ARR_W-1:0]    best_arr_r;
  logic [SVC_W-1:0]    best_svc_r;
  logic [TICK_W-1:0]   earliest_r;

  logic [IDX_W-1:0]    out_idx_r;
  logic [TICK_W-1:0]   out_start_r;
  logic [WAIT_W-1:0]   out_wait_r;
  logic [TURN_W-1:0]   out_turn_r;
  logic                out_final_r;

  logic [CNT_W-1:0]    last_addr;
  logic                pending;
  logic                take;
  logic                new_min;
  logic [TICK_W-1:0]   wait_full;
  logic [WAIT_W-1:0]   wait_nxt;
  logic [TURN_W-1:0]   turn_nxt;
  logic [DIVD_W-1:0]   quo_w;
  logic [DIVD_W-1:0]   quo_t;
  logic                done_w;
  logic                done_t;

  assign last_addr = count_r - CNT_W'(1);
  assign pending   = cmp_vld_r && !done_r[cmp_idx_r];
  assign take      = pending && ({1'b0, rd_arr_r} <= tick_r)
                     && (!best_found_r || rd_svc_r < best_svc_r);
  assign new_min   = pending && ({1'b0, rd_arr_r} < earliest_r);
  assign wait_full = tick_r - {1'b0, best_arr_r};
  assign wait_nxt  = wait_full[WAIT_W-1:0];
  assign turn_nxt  = {1'b0, wait_nxt} + {{(TURN_W-SVC_W){1'b0}}, best_svc_r};

  // Job stores: written on load, read one entry per cycle during a scan.
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CNT_W'(MAX_JOBS)) begin
      arr_mem[count_r[IDX_W-1:0]] <= in_arrival_time;
      svc_mem[count_r[IDX_W-1:0]] <= in_service_time;
    end
    rd_arr_r  <= arr_mem[scan_addr_r[IDX_W-1:0]];
    rd_svc_r  <= svc_mem[scan_addr_r[IDX_W-1:0]];
    cmp_idx_r <= scan_addr_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r       <= '0;
      count_r      <= '0;
      tick_r       <= '0;
      wsum_r       <= '0;
      tsum_r       <= '0;
      disp_cnt_r   <= '0;
      scan_addr_r  <= '0;
      issuing_r    <= 1'b0;
      cmp_vld_r    <= 1'b0;
      cmp_last_r   <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.load && count_r < CNT_W'(MAX_JOBS)) begin
        count_r <= count_r + CNT_W'(1);
      end
      cmp_vld_r  <= issuing_r;
      cmp_last_r <= issuing_r && (scan_addr_r == last_addr);
      if (cmd.scan_init) begin
        scan_addr_r  <= '0;
        issuing_r    <= 1'b1;
        best_found_r <= 1'b0;
      end else if (issuing_r) begin
        scan_addr_r <= scan_addr_r + CNT_W'(1);
        if (scan_addr_r == last_addr) begin
          issuing_r <= 1'b0;
        end
      end
      if (take) begin
        best_found_r <= 1'b1;
      end
      if (cmd.jump) begin
        tick_r <= earliest_r;
      end
      if (cmd.dispatch) begin
        done_r[best_idx_r] <= 1'b1;
        disp_cnt_r <= disp_cnt_r + IDX_W'(1);
        tick_r     <= tick_r + {{(TICK_W-SVC_W){1'b0}}, best_svc_r};
        wsum_r     <= wsum_r + {{(SUM_W-WAIT_W){1'b0}}, wait_nxt};
        tsum_r     <= tsum_r + {{(SUM_W-TURN_W){1'b0}}, turn_nxt};
      end
      if (cmd.clear) begin
        done_r     <= '0;
        count_r    <= '0;
        tick_r     <= '0;
        wsum_r     <= '0;
        tsum_r     <= '0;
        disp_cnt_r <= '0;
      end
    end
  end

  // Best candidate and earliest pending arrival of the current scan.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      earliest_r <= '1;
    end else if (new_min) begin
      earliest_r <= {1'b0, rd_arr_r};
    end
    if (take) begin
      best_idx_r <= cmp_idx_r;
      best_arr_r <= rd_arr_r;
      best_svc_r <= rd_svc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dispatch) begin
      out_idx_r   <= best_idx_r;
      out_start_r <= tick_r;
      out_wait_r  <= wait_nxt;
      out_turn_r  <= turn_nxt;
      out_final_r <= stat.last_disp;
    end
  end

  sps_div u_div_wait (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({wsum_r, {FRAC_W{1'b0}}}),
    .divisor  (count_r),
    .quotient (quo_w),
    .done     (done_w)
  );

  sps_div u_div_turn (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({tsum_r, {FRAC_W{1'b0}}}),
    .divisor  (count_r),
    .quotient (quo_t),
    .done     (done_t)
  );

  always_comb begin
    stat.scan_done  = cmp_vld_r && cmp_last_r;
    stat.best_found = best_found_r;
    stat.last_disp  = {1'b0, disp_cnt_r} == last_addr;
    stat.div_done   = done_w && done_t;
  end

  assign out_job_index         = out_idx_r;
  assign out_start_time        = out_start_r;
  assign out_wait_ticks        = out_wait_r;
  assign out_turnaround_ticks  = out_turn_r;
  assign out_final_dispatch    = out_final_r;
  assign out_avg_wait_q8       = out_final_r ? quo_w[AVGW_W-1:0] : '0;
  assign out_avg_turnaround_q8 = out_final_r ? quo_t[AVGT_W-1:0] : '0;

endmodule

// ----- hdl/sps_ctrl.sv -----
// Controller state machine that sequences loading, scans, dispatches and the final division.
module sps_ctrl
  import sps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last_job,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INIT   = 4'd1;
  localparam logic [3:0] ST_SCAN   = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_DISP   = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_DIVGO  = 4'd6;
  localparam logic [3:0] ST_DIVW   = 4'd7;
  localparam logic [3:0] ST_FINAL  = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_job) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.scan_init = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.best_found) begin
          state_nxt = ST_DISP;
        end else begin
          cmd.jump  = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_DISP: begin
        cmd.dispatch = 1'b1;
        state_nxt    = stat.last_disp ? ST_DIVGO : ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (stat.div_done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        out_valid = 1'b1;
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule

// ----- verif/spn_dispatch_checker.sv -----
// Checker that predicts the dispatch schedule of each batch and compares every result beat.
module spn_dispatch_checker
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [ARR_W-1:0]  in_arrival_time,
  input  logic [SVC_W-1:0]  in_service_time,
  input  logic              in_last_job,
  input  logic              out_valid,
  input  logic [IDX_W-1:0]  out_job_index,
  input  logic [TICK_W-1:0] out_start_time,
  input  logic [WAIT_W-1:0] out_wait_ticks,
  input  logic [TURN_W-1:0] out_turnaround_ticks,
  input  logic [AVGW_W-1:0] out_avg_wait_q8,
  input  logic [AVGT_W-1:0] out_avg_turnaround_q8,
  input  logic              out_final_dispatch,
  output int                mismatches,
  output int                pending
);

  typedef struct {
    logic [IDX_W-1:0]  job_index;
    logic [TICK_W-1:0] start_time;
    logic [WAIT_W-1:0] wait_ticks;
    logic [TURN_W-1:0] turnaround_ticks;
    logic [AVGW_W-1:0] avg_wait_q8;
    logic [AVGT_W-1:0] avg_turnaround_q8;
    logic              final_dispatch;
  } dispatch_t;

  dispatch_t        dispatch_q[$];
  logic [ARR_W-1:0] arrival_mem[MAX_JOBS];
  logic [SVC_W-1:0] service_mem[MAX_JOBS];
  bit               finished[MAX_JOBS];
  int               stored_jobs;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  function automatic int shortest_ready(input logic [TICK_W-1:0] now);
    int best;
    best = -1;
    for (int j = 0; j < stored_jobs; j++) begin
      if (!finished[j] && arrival_mem[j] <= now &&
          (best < 0 || service_mem[j] < service_mem[best])) begin
        best = j;
      end
    end
    return best;
  endfunction

  function automatic void plan_batch();
    logic [TICK_W-1:0] tick;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  turn_sum;
    logic [WAIT_W-1:0] w;
    logic [TURN_W-1:0] t;
    logic [ARR_W:0]    earliest;
    int                pick;
    dispatch_t         d;
    tick     = '0;
    wait_sum = '0;
    turn_sum = '0;
    for (int j = 0; j < MAX_JOBS; j++) begin
      finished[j] = 1'b0;
    end
    for (int k = 0; k < stored_jobs; k++) begin
      pick = shortest_ready(tick);
      if (pick < 0) begin
        // Nothing has arrived yet, so time jumps to the earliest pending arrival.
        earliest = {1'b1, {ARR_W{1'b0}}};
        for (int j = 0; j < stored_jobs; j++) begin
          if (!finished[j] && arrival_mem[j] < earliest) begin
            earliest = arrival_mem[j];
          end
        end
        tick = earliest;
        pick = shortest_ready(tick);
      end
      finished[pick] = 1'b1;
      w = tick - arrival_mem[pick];
      t = w + service_mem[pick];
      wait_sum = wait_sum + w;
      turn_sum = turn_sum + t;
      d.job_index         = IDX_W'(pick);
      d.start_time        = tick;
      d.wait_ticks        = w;
      d.turnaround_ticks  = t;
      d.avg_wait_q8       = '0;
      d.avg_turnaround_q8 = '0;
      d.final_dispatch    = 1'b0;
      if (k == stored_jobs - 1) begin
        d.avg_wait_q8       = {wait_sum, 8'h00} / stored_jobs;
        d.avg_turnaround_q8 = {turn_sum, 8'h00} / stored_jobs;
        d.final_dispatch    = 1'b1;
      end
      dispatch_q.push_back(d);
      tick = tick + service_mem[pick];
    end
  endfunction

  always @(posedge clk) begin : watch
    dispatch_t want;
    if (!rst_n) begin
      dispatch_q.delete();
      stored_jobs = 0;
      mismatches  = 0;
    end else begin
      if (out_valid) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch($sformatf("result beat for job %0d with none outstanding",
                                    out_job_index));
        end else begin
          want = dispatch_q.pop_front();
          compare_field("job_index", out_job_index, want.job_index);
          compare_field("start_time", out_start_time, want.start_time);
          compare_field("wait_ticks", out_wait_ticks, want.wait_ticks);
          compare_field("turnaround_ticks", out_turnaround_ticks, want.turnaround_ticks);
          compare_field("avg_wait_q8", out_avg_wait_q8, want.avg_wait_q8);
          compare_field("avg_turnaround_q8", out_avg_turnaround_q8,
                        want.avg_turnaround_q8);
          compare_field("final_dispatch", out_final_dispatch, want.final_dispatch);
        end
      end
      if (start && !busy) begin
        // Once the batch is full, further jobs are dropped but a last beat still runs it.
        if (stored_jobs < MAX_JOBS) begin
          arrival_mem[stored_jobs] = in_arrival_time;
          service_mem[stored_jobs] = in_service_time;
          stored_jobs++;
        end
        if (in_last_job) begin
          plan_batch();
          stored_jobs = 0;
        end
      end
    end
    pending = dispatch_q.size();
  end

endmodule

// ----- verif/shortest_process_next_sched_top_tb.sv -----
// Testbench top: drives job batches into the scheduler and gives the verdict.
module shortest_process_next_sched_top_tb
  import sps_pkg::*;
();

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ARR_W-1:0]  in_arrival_time;
  logic [SVC_W-1:0]  in_service_time;
  logic              in_last_job;
  logic              out_valid;
  logic [IDX_W-1:0]  out_job_index;
  logic [TICK_W-1:0] out_start_time;
  logic [WAIT_W-1:0] out_wait_ticks;
  logic [TURN_W-1:0] out_turnaround_ticks;
  logic [AVGW_W-1:0] out_avg_wait_q8;
  logic [AVGT_W-1:0] out_avg_turnaround_q8;
  logic              out_final_dispatch;
  int                mismatches;
  int                pending;
  int                jobs_sent;

  always #10 clk = ~clk;

  shortest_process_next_sched_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_arrival_time       (in_arrival_time),
    .in_service_time       (in_service_time),
    .in_last_job           (in_last_job),
    .out_valid             (out_valid),
    .out_job_index         (out_job_index),
    .out_start_time        (out_start_time),
    .out_wait_ticks        (out_wait_ticks),
    .out_turnaround_ticks  (out_turnaround_ticks),
    .out_avg_wait_q8       (out_avg_wait_q8),
    .out_avg_turnaround_q8 (out_avg_turnaround_q8),
    .out_final_dispatch    (out_final_dispatch)
  );

  spn_dispatch_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_arrival_time       (in_arrival_time),
    .in_service_time       (in_service_time),
    .in_last_job           (in_last_job),
    .out_valid             (out_valid),
    .out_job_index         (out_job_index),
    .out_start_time        (out_start_time),
    .out_wait_ticks        (out_wait_ticks),
    .out_turnaround_ticks  (out_turnaround_ticks),
    .out_avg_wait_q8       (out_avg_wait_q8),
    .out_avg_turnaround_q8 (out_avg_turnaround_q8),
    .out_final_dispatch    (out_final_dispatch),
    .mismatches            (mismatches),
    .pending               (pending)
  );

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_job(input logic [ARR_W-1:0] arr, input logic [SVC_W-1:0] svc,
                          input logic last, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_arrival_time <= ARR_W'($urandom);
      in_service_time <= SVC_W'($urandom);
      in_last_job     <= 1'($urandom);
      @(negedge clk);
    end
    start           <= 1'b1;
    in_arrival_time <= arr;
    in_service_time <= svc;
    in_last_job     <= last;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    jobs_sent++;
    @(negedge clk);
  endtask

  task automatic random_batch(input int n, input int idle_pct);
    bit               wide;
    int               span;
    logic [ARR_W-1:0] arr;
    logic [SVC_W-1:0] svc;
    wide = 1'($urandom_range(0, 1));
    span = $urandom_range(1, 40 * n);
    for (int i = 0; i < n; i++) begin
      arr = wide ? ARR_W'($urandom) : ARR_W'($urandom_range(0, span));
      svc = ($urandom_range(0, 3) == 0) ? SVC_W'($urandom_range(0, 3))
                                        : SVC_W'($urandom_range(0, 255));
      send_job(arr, svc, i == n - 1, idle_pct);
    end
  endtask

  initial begin : stimulus
    int batch_no;
    int idle_pct;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_arrival_time = '0;
    in_service_time = '0;
    in_last_job     = 1'b0;
    jobs_sent       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_job(16'hFFFF, 8'hFF, 1'b1, 0);
    send_job(16'd5, 8'd10, 1'b0, 0);
    send_job(16'd0, 8'd255, 1'b0, 0);
    send_job(16'd0, 8'd10, 1'b0, 0);
    send_job(16'd3, 8'd10, 1'b0, 0);
    send_job(16'd0, 8'd0, 1'b1, 0);
    send_job(16'd100, 8'd5, 1'b0, 0);
    send_job(16'd200, 8'd3, 1'b0, 0);
    send_job(16'd1000, 8'd1, 1'b1, 0);
    send_job(16'd0, 8'd0, 1'b1, 0);
    send_job(16'd0, 8'd200, 1'b0, 0);
    send_job(16'd1, 8'd1, 1'b0, 0);
    send_job(16'd2, 8'd2, 1'b0, 0);
    send_job(16'd1, 8'd0, 1'b1, 0);

    batch_no = 0;
    while (jobs_sent < 180) begin
      unique case ((batch_no / 3) % 4)
        0: begin
          idle_pct = 0;
        end
        1: begin
          idle_pct = 76;
        end
        2: begin
          idle_pct = 13;
        end
        default: begin
          idle_pct = 0;
        end
      endcase
      if (batch_no == 6) begin
        // A full batch with long services, then one dropped job and a dropped last beat.
        for (int i = 0; i < MAX_JOBS + 2; i++) begin
          send_job(ARR_W'($urandom_range(0, 15)), SVC_W'($urandom_range(224, 255)),
                   i == MAX_JOBS + 1, idle_pct);
        end
      end else begin
        random_batch($urandom_range(1, 10), idle_pct);
      end
      batch_no++;
    end
    start <= 1'b0;

    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("shortest_process_next_sched_top_tb passed");
    end else begin
      $display("shortest_process_next_sched_top_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("shortest_process_next_sched_top_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sps_pkg.sv
hdl/sps_div.sv
hdl/sps_dp.sv
hdl/sps_ctrl.sv
hdl/shortest_process_next_sched_top.sv
verif/spn_dispatch_checker.sv
verif/shortest_process_next_sched_top_tb.sv
